// File: design/sdr_pkg.sv
// shared types, constants and helpers for the slew limited dac ramp
`timescale 1ns / 1ps

package sdr_pkg;

   localparam int VOLT_W     = 20;
   localparam int OFFSET_W   = 21;
   localparam int TIME_W     = 32;
   localparam int CODE_W     = 12;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   localparam logic [VOLT_W-1:0] US_PER_SECOND = 20'd1000000;

   localparam logic [VOLT_W-1:0]   RST_V_MIN           = 20'd0;
   localparam logic [VOLT_W-1:0]   RST_V_MAX           = 20'd327680;
   localparam logic [VOLT_W-1:0]   RST_SLEW_RATE       = 20'd131072;
   localparam logic [VOLT_W-1:0]   RST_UPDATE_INTERVAL = 20'd2000;
   localparam logic [OFFSET_W-1:0] RST_CAL_OFFSET      = 21'd0;
   localparam logic [VOLT_W-1:0]   RST_CAL_GAIN_RECIP  = 20'd65536;
   localparam logic [VOLT_W-1:0]   RST_CODE_PER_VOLT   = 20'd209664;
   localparam logic [VOLT_W-1:0]   RST_MIN_STEP        = 20'd80;

   typedef enum logic [2:0] {
      CSR_V_MIN           = 3'd0,
      CSR_V_MAX           = 3'd1,
      CSR_SLEW_RATE       = 3'd2,
      CSR_UPDATE_INTERVAL = 3'd3,
      CSR_CAL_OFFSET      = 3'd4,
      CSR_CAL_GAIN_RECIP  = 3'd5,
      CSR_CODE_PER_VOLT   = 3'd6,
      CSR_MIN_STEP        = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [VOLT_W-1:0]          v_min;
      logic [VOLT_W-1:0]          v_max;
      logic [VOLT_W-1:0]          slew_rate;
      logic [VOLT_W-1:0]          update_interval;
      logic signed [OFFSET_W-1:0] cal_offset;
      logic [VOLT_W-1:0]          cal_gain_recip;
      logic [VOLT_W-1:0]          code_per_volt;
      logic [VOLT_W-1:0]          min_step;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SLEW_MUL,
      ST_SLEW_DIV,
      ST_APPLY,
      ST_CODE,
      ST_GAIN_MUL,
      ST_SCALE_MUL,
      ST_FINISH
   } state_type;

   // low bound is tested first, so with an inverted range a value below lo gives lo and any other gives hi
   function automatic logic [VOLT_W-1:0] clamp_volts(input logic [VOLT_W-1:0] v,
                                                      input logic [VOLT_W-1:0] lo,
                                                      input logic [VOLT_W-1:0] hi);
      logic [VOLT_W-1:0] r;
      priority if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: design/sdr_csr.sv
// apb register file holding the ramp and conversion settings
`timescale 1ns / 1ps

module sdr_csr
   import sdr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_V_MIN:           cfg_in.v_min           = csr_pwdata[VOLT_W-1:0];
            CSR_V_MAX:           cfg_in.v_max           = csr_pwdata[VOLT_W-1:0];
            CSR_SLEW_RATE:       cfg_in.slew_rate       = csr_pwdata[VOLT_W-1:0];
            CSR_UPDATE_INTERVAL: cfg_in.update_interval = csr_pwdata[VOLT_W-1:0];
            CSR_CAL_OFFSET:      cfg_in.cal_offset      = csr_pwdata[OFFSET_W-1:0];
            CSR_CAL_GAIN_RECIP:  cfg_in.cal_gain_recip  = csr_pwdata[VOLT_W-1:0];
            CSR_CODE_PER_VOLT:   cfg_in.code_per_volt   = csr_pwdata[VOLT_W-1:0];
            CSR_MIN_STEP:        cfg_in.min_step        = csr_pwdata[VOLT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_V_MIN:           csr_prdata = CSR_DATA_W'(cfg_ff.v_min);
         CSR_V_MAX:           csr_prdata = CSR_DATA_W'(cfg_ff.v_max);
         CSR_SLEW_RATE:       csr_prdata = CSR_DATA_W'(cfg_ff.slew_rate);
         CSR_UPDATE_INTERVAL: csr_prdata = CSR_DATA_W'(cfg_ff.update_interval);
         CSR_CAL_OFFSET:      csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.cal_offset));
         CSR_CAL_GAIN_RECIP:  csr_prdata = CSR_DATA_W'(cfg_ff.cal_gain_recip);
         CSR_CODE_PER_VOLT:   csr_prdata = CSR_DATA_W'(cfg_ff.code_per_volt);
         CSR_MIN_STEP:        csr_prdata = CSR_DATA_W'(cfg_ff.min_step);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.v_min           <= RST_V_MIN;
         cfg_ff.v_max           <= RST_V_MAX;
         cfg_ff.slew_rate       <= RST_SLEW_RATE;
         cfg_ff.update_interval <= RST_UPDATE_INTERVAL;
         cfg_ff.cal_offset      <= RST_CAL_OFFSET;
         cfg_ff.cal_gain_recip  <= RST_CAL_GAIN_RECIP;
         cfg_ff.code_per_volt   <= RST_CODE_PER_VOLT;
         cfg_ff.min_step        <= RST_MIN_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/sdr_serial_mul.sv
// shift-add multiplier taking one multiplier bit per cycle
`timescale 1ns / 1ps

module sdr_serial_mul #(
   parameter int A_W = 20,
   parameter int B_W = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               done,
   output logic [A_W+B_W-1:0] product
);

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(B_W);

   logic [P_W-1:0]   prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [A_W:0]     sum;

   assign done    = done_ff;
   assign product = prod_ff;

   always_comb begin
      sum     = {1'b0, prod_ff[P_W-1:B_W]} + (prod_ff[0] ? {1'b0, a} : '0);
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         prod_in = {{A_W{1'b0}}, b};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[B_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: design/sdr_serial_div.sv
// restoring divider producing one quotient bit per cycle
`timescale 1ns / 1ps

module sdr_serial_div #(
   parameter int N_W = 52,
   parameter int D_W = 20
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [N_W-1:0] quotient
);

   localparam int CNT_W = $clog2(N_W);

   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     trial;
   logic [D_W:0]     diff;
   logic             ge;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      trial   = {rem_ff, quo_ff[N_W-1]};
      diff    = trial - {1'b0, divisor};
      ge      = (trial >= {1'b0, divisor});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[N_W-2:0], ge};
         rem_in = ge ? diff[D_W-1:0] : trial[D_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

endmodule

// File: design/slew_limited_dac_ramp.sv
// top level of the slew limited voltage ramp with dac code conversion
//
// req channel: one tick per transfer, timestamp in microseconds and a target
// voltage (Q4.16). rsp channel: exactly one result per tick with the updated
// and write_strobe flags, the dac code and the present voltage.
// csr port: apb style, eight 20 bit registers (the offset 21 bit) at byte addresses
// 4*i, pready is always high; write only while no tick is in flight.
// one tick at a time. a tick that does not reach the update interval goes
// straight to the dac code; an updating tick with a nonzero slew rate first
// forms its step, one with a zero slew rate moves to the target at once. the
// two code multiplies are skipped when the corrected voltage is not above
// zero. the step size is formed by a bit serial 20x32 multiply and a bit
// serial divide by one million; the dac code by two bit serial multiplies.
// req_stall is high while a tick is in work and drops as the result is loaded.
// a finished result waits in the output register while rsp_stall is high;
// the next tick can be taken meanwhile and stops before its result until the
// register is free.
// reset (synchronous) clears the ramp state to zero volts, marks the dac as
// never written and loads the register defaults.
`timescale 1ns / 1ps

module slew_limited_dac_ramp
   import sdr_pkg::*;
#(
   parameter int DAC_CODE_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TIME_W-1:0]     req_now_us,
   input  logic [VOLT_W-1:0]     req_target_volts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_updated,
   output logic                  rsp_write_strobe,
   output logic [CODE_W-1:0]     rsp_dac_code,
   output logic [VOLT_W-1:0]     rsp_current_volts,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int STEP_W  = VOLT_W + TIME_W;
   localparam int D_W     = VOLT_W + 2;
   localparam int GAIN_W  = (D_W - 1) + VOLT_W;
   localparam int SCALE_W = GAIN_W + VOLT_W;
   localparam int FRAC_W  = 40;
   localparam int RND_W   = SCALE_W - FRAC_W + 1;
   localparam logic [RND_W-1:0] MaxCode = RND_W'((1 << DAC_CODE_BITS) - 1);

   cfg_type cfg;

   state_type state_ff, state_in;

   logic [TIME_W-1:0] now_ff, now_in;
   logic [VOLT_W-1:0] req_ff, req_in;
   logic [VOLT_W-1:0] target_ff, target_in;
   logic [VOLT_W-1:0] current_ff, current_in;
   logic [VOLT_W-1:0] last_wr_ff, last_wr_in;
   logic              written_ff, written_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic              upd_ff, upd_in;
   logic              strobe_ff, strobe_in;
   logic              code_zero_ff, code_zero_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_updated_ff, rsp_updated_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic [VOLT_W-1:0] rsp_volts_ff, rsp_volts_in;

   // control from the sequencer
   logic accept, slew_start, div_start, gain_start, scale_start, load_out;

   logic [TIME_W-1:0]  elapsed;
   logic               skip;
   logic               slew_zero;
   logic               out_free;
   logic               slew_done, div_done, gain_done, scale_done;
   logic [STEP_W-1:0]  slew_prod, step_quo;
   logic [GAIN_W-1:0]  gain_prod;
   logic [SCALE_W-1:0] scale_prod;

   logic signed [D_W-1:0] d_full;
   logic                  d_pos;

   logic              up;
   logic [VOLT_W-1:0] err_mag;
   logic              step_big;
   logic              partial;
   logic [VOLT_W-1:0] next_raw, next_val, wr_diff;
   logic              do_write;
   logic [RND_W-1:0]  rounded, code_sat;

   sdr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdr_serial_mul #(.A_W(VOLT_W), .B_W(TIME_W)) u_slew_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (slew_start),
      .a       (cfg.slew_rate),
      .b       (elapsed),
      .done    (slew_done),
      .product (slew_prod)
   );

   sdr_serial_div #(.N_W(STEP_W), .D_W(VOLT_W)) u_step_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (slew_prod),
      .divisor  (US_PER_SECOND),
      .done     (div_done),
      .quotient (step_quo)
   );

   sdr_serial_mul #(.A_W(D_W - 1), .B_W(VOLT_W)) u_gain_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (gain_start),
      .a       (d_full[D_W-2:0]),
      .b       (cfg.cal_gain_recip),
      .done    (gain_done),
      .product (gain_prod)
   );

   sdr_serial_mul #(.A_W(GAIN_W), .B_W(VOLT_W)) u_scale_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (scale_start),
      .a       (gain_prod),
      .b       (cfg.code_per_volt),
      .done    (scale_done),
      .product (scale_prod)
   );

   // shared datapath terms
   always_comb begin
      elapsed   = now_ff - last_time_ff;
      skip      = elapsed < TIME_W'(cfg.update_interval);
      slew_zero = (cfg.slew_rate == '0);
      out_free  = !rsp_valid_ff || !rsp_stall;
      d_full    = $signed({2'b00, current_ff}) - $signed({cfg.cal_offset[OFFSET_W-1],
                                                          cfg.cal_offset});
      d_pos     = !d_full[D_W-1] && (d_full != '0);

      up       = target_ff > current_ff;
      err_mag  = up ? target_ff - current_ff : current_ff - target_ff;
      step_big = |step_quo[STEP_W-1:VOLT_W];
      partial  = !slew_zero && !step_big && (err_mag > step_quo[VOLT_W-1:0]);
      if (partial) begin
         next_raw = up ? current_ff + step_quo[VOLT_W-1:0]
                       : current_ff - step_quo[VOLT_W-1:0];
      end else begin
         next_raw = target_ff;
      end
      next_val = clamp_volts(next_raw, cfg.v_min, cfg.v_max);
      wr_diff  = (next_val >= last_wr_ff) ? next_val - last_wr_ff : last_wr_ff - next_val;
      do_write = !written_ff || (wr_diff >= cfg.min_step);

      rounded  = {1'b0, scale_prod[SCALE_W-1:FRAC_W]} + RND_W'(scale_prod[FRAC_W-1]);
      code_sat = (rounded > MaxCode) ? MaxCode : rounded;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            priority if (skip) begin
               state_in = ST_CODE;
            end else if (slew_zero) begin
               state_in = ST_APPLY;
            end else begin
               state_in = ST_SLEW_MUL;
            end
         end
         ST_SLEW_MUL: begin
            if (slew_done) state_in = ST_SLEW_DIV;
         end
         ST_SLEW_DIV: begin
            if (div_done) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_CODE;
         end
         ST_CODE: begin
            state_in = d_pos ? ST_GAIN_MUL : ST_FINISH;
         end
         ST_GAIN_MUL: begin
            if (gain_done) state_in = ST_SCALE_MUL;
         end
         ST_SCALE_MUL: begin
            if (scale_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      accept      = (state_ff == ST_IDLE) && req_valid;
      slew_start  = (state_ff == ST_EVAL) && !skip && !slew_zero;
      div_start   = (state_ff == ST_SLEW_MUL) && slew_done;
      gain_start  = (state_ff == ST_CODE) && d_pos;
      scale_start = (state_ff == ST_GAIN_MUL) && gain_done;
      load_out    = (state_ff == ST_FINISH) && out_free;
   end

   // ramp state and result register
   always_comb begin
      now_in       = now_ff;
      req_in       = req_ff;
      target_in    = target_ff;
      current_in   = current_ff;
      last_wr_in   = last_wr_ff;
      written_in   = written_ff;
      last_time_in = last_time_ff;
      upd_in       = upd_ff;
      strobe_in    = strobe_ff;
      code_zero_in = code_zero_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_updated_in = rsp_updated_ff;
      rsp_strobe_in  = rsp_strobe_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_volts_in   = rsp_volts_ff;

      if (accept) begin
         now_in = req_now_us;
         req_in = req_target_volts;
      end
      if (state_ff == ST_EVAL) begin
         target_in = clamp_volts(req_ff, cfg.v_min, cfg.v_max);
         upd_in    = 1'b0;
         strobe_in = 1'b0;
      end
      if (state_ff == ST_APPLY) begin
         current_in   = next_val;
         last_time_in = now_ff;
         upd_in       = 1'b1;
         strobe_in    = do_write;
         if (do_write) begin
            last_wr_in = next_val;
            written_in = 1'b1;
         end
      end
      if (state_ff == ST_CODE) begin
         code_zero_in = !d_pos;
      end
      if (load_out) begin
         rsp_valid_in   = 1'b1;
         rsp_updated_in = upd_ff;
         rsp_strobe_in  = strobe_ff;
         rsp_code_in    = code_zero_ff ? '0 : code_sat[CODE_W-1:0];
         rsp_volts_in   = current_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= '0;
         current_ff   <= '0;
         last_wr_ff   <= '0;
         written_ff   <= 1'b0;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         current_ff   <= current_in;
         last_wr_ff   <= last_wr_in;
         written_ff   <= written_in;
         last_time_ff <= last_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      req_ff         <= req_in;
      upd_ff         <= upd_in;
      strobe_ff      <= strobe_in;
      code_zero_ff   <= code_zero_in;
      rsp_updated_ff <= rsp_updated_in;
      rsp_strobe_ff  <= rsp_strobe_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_volts_ff   <= rsp_volts_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_updated       = rsp_updated_ff;
   assign rsp_write_strobe  = rsp_strobe_ff;
   assign rsp_dac_code      = rsp_code_ff;
   assign rsp_current_volts = rsp_volts_ff;

endmodule
